// ===== src/ubxfr_pkg.sv =====
package ubxfr_pkg;

  localparam int MAX_FRAME = 4096;

  localparam int CNT_W = 17;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [15:0] TYPE_NAV_SOLUTION   = 16'h0106;
  localparam logic [15:0] TYPE_TRACK_MEAS     = 16'h0310;
  localparam logic [15:0] TYPE_TRACK_SUBFRAME = 16'h030F;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CHECKSUM = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  localparam logic [1:0] KIND_OTHER    = 2'd0;
  localparam logic [1:0] KIND_NAV_SOL  = 2'd1;
  localparam logic [1:0] KIND_TRK_MEAS = 2'd2;
  localparam logic [1:0] KIND_TRK_SFRM = 2'd3;

  localparam logic [CNT_W-1:0] POS_HUNT     = CNT_W'(0);
  localparam logic [CNT_W-1:0] POS_CLASS    = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_ID       = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_LEN_LO   = CNT_W'(4);
  localparam logic [CNT_W-1:0] POS_LEN_HI   = CNT_W'(5);
  localparam logic [CNT_W-1:0] FRAME_EXTRA  = CNT_W'(8);
  localparam logic [CNT_W-1:0] CHECK_BYTES  = CNT_W'(2);
  localparam logic [CNT_W-1:0] MAX_FRAME_C  = CNT_W'(MAX_FRAME);

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_len;
    logic [1:0]  msg_kind;
  } result_t;

  function automatic logic [1:0] classify(input logic [7:0] cls, input logic [7:0] id);
    logic [15:0] msg_type;
    logic [1:0]  kind;
    msg_type = {cls, id};
    if (msg_type == TYPE_NAV_SOLUTION) begin
      kind = KIND_NAV_SOL;
    end else if (msg_type == TYPE_TRACK_MEAS) begin
      kind = KIND_TRK_MEAS;
    end else if (msg_type == TYPE_TRACK_SUBFRAME) begin
      kind = KIND_TRK_SFRM;
    end else begin
      kind = KIND_OTHER;
    end
    return kind;
  endfunction

endpackage

// ===== src/ubxfr_frame_parser.sv =====
module ubxfr_frame_parser
  import ubxfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] data_byte,
  input  logic       advance,
  output logic       emit,
  output result_t    result
);

  logic [7:0]       prev_byte_r,    prev_byte_nxt;
  logic [CNT_W-1:0] byte_count_r,   byte_count_nxt;
  logic [CNT_W-1:0] frame_length_r, frame_length_nxt;
  logic [7:0]       check_a_r,      check_a_nxt;
  logic [7:0]       check_b_r,      check_b_nxt;
  logic [7:0]       class_r,        class_nxt;
  logic [7:0]       id_r,           id_nxt;
  logic [7:0]       recv_check_a_r, recv_check_a_nxt;
  logic [7:0]       sum_a;
  logic [7:0]       sum_b;
  logic [1:0]       status;

  assign sum_a = check_a_r + data_byte;
  assign sum_b = check_b_r + sum_a;

  always_comb begin
    prev_byte_nxt    = prev_byte_r;
    byte_count_nxt   = byte_count_r;
    frame_length_nxt = frame_length_r;
    check_a_nxt      = check_a_r;
    check_b_nxt      = check_b_r;
    class_nxt        = class_r;
    id_nxt           = id_r;
    recv_check_a_nxt = recv_check_a_r;
    emit             = 1'b0;
    status           = ST_OK;
    if (byte_count_r == POS_HUNT) begin
      prev_byte_nxt = data_byte;
      if (prev_byte_r == SYNC_FIRST && data_byte == SYNC_SECOND) begin
        byte_count_nxt = POS_CLASS;
        check_a_nxt    = 8'd0;
        check_b_nxt    = 8'd0;
      end
    end else begin
      byte_count_nxt = byte_count_r + CNT_W'(1);
      if (byte_count_r <= POS_LEN_HI) begin
        check_a_nxt = sum_a;
        check_b_nxt = sum_b;
        unique case (byte_count_r)
          POS_CLASS:  class_nxt = data_byte;
          POS_ID:     id_nxt    = data_byte;
          POS_LEN_LO: frame_length_nxt = {{(CNT_W-8){1'b0}}, data_byte};
          POS_LEN_HI: begin
            frame_length_nxt = {1'b0, data_byte, frame_length_r[7:0]} + FRAME_EXTRA;
            if (frame_length_nxt > MAX_FRAME_C) begin
              byte_count_nxt = POS_HUNT;
              emit           = 1'b1;
              status         = ST_TOO_LONG;
            end
          end
          default: ;
        endcase
      end else if (byte_count_r < frame_length_r - CHECK_BYTES) begin
        check_a_nxt = sum_a;
        check_b_nxt = sum_b;
      end else if (byte_count_r == frame_length_r - CHECK_BYTES) begin
        recv_check_a_nxt = data_byte;
      end else begin
        byte_count_nxt = POS_HUNT;
        emit           = 1'b1;
        status = (recv_check_a_r == check_a_r && data_byte == check_b_r) ? ST_OK : ST_CHECKSUM;
      end
    end
  end

  always_comb begin
    result.status      = status;
    result.msg_class   = class_nxt;
    result.msg_id      = id_nxt;
    result.payload_len = 16'(frame_length_nxt - FRAME_EXTRA);
    result.msg_kind    = classify(class_nxt, id_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_byte_r    <= 8'd0;
      byte_count_r   <= POS_HUNT;
      frame_length_r <= '0;
      check_a_r      <= 8'd0;
      check_b_r      <= 8'd0;
      class_r        <= 8'd0;
      id_r           <= 8'd0;
      recv_check_a_r <= 8'd0;
    end else if (advance) begin
      prev_byte_r    <= prev_byte_nxt;
      byte_count_r   <= byte_count_nxt;
      frame_length_r <= frame_length_nxt;
      check_a_r      <= check_a_nxt;
      check_b_r      <= check_b_nxt;
      class_r        <= class_nxt;
      id_r           <= id_nxt;
      recv_check_a_r <= recv_check_a_nxt;
    end
  end

endmodule

// ===== src/ubxfr_result_reg.sv =====
module ubxfr_result_reg
  import ubxfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_data,
  output logic    free,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== src/ubx_frame_receiver_core.sv =====
// Frame receiver for a binary GNSS serial stream with 0xB5 0x62 sync.
// Input channel: one received byte per transfer on in_data_byte, flow
// controlled by in_valid / in_stall. Output channel: one result per frame
// (status, class, id, payload length, message kind) by out_valid / out_stall.
// A byte is held in an input register, then parsed combinationally against the
// frame state and checksum; a frame result lands in an output register.
// Throughput: one byte per cycle, sustained, as long as out_stall stays low.
// The result of the last byte of a frame (or of the high length byte for an
// oversized frame) passes the input register, then the output register,
// before it shows on out_valid.
// While a result waits under out_stall, bytes that finish no frame keep
// flowing; a byte that would finish a frame holds in the input register and
// in_stall rises until the pending result is taken.
// Reset (rst_n low, synchronous) empties both registers, clears the checksum
// and frame state and starts hunting for sync.
module ubx_frame_receiver_core
  import ubxfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_msg_class,
  output logic [7:0]  out_msg_id,
  output logic [15:0] out_payload_len,
  output logic [1:0]  out_msg_kind
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       emit;
  logic       out_free;
  logic       advance;
  result_t    result;
  result_t    out_data;

  assign advance  = in_valid_r && (!emit || out_free);
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_data_byte;
    end
  end

  ubxfr_frame_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .data_byte (in_byte_r),
    .advance   (advance),
    .emit      (emit),
    .result    (result)
  );

  ubxfr_result_reg u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && emit),
    .load_data (result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_status      = out_data.status;
  assign out_msg_class   = out_data.msg_class;
  assign out_msg_id      = out_data.msg_id;
  assign out_payload_len = out_data.payload_len;
  assign out_msg_kind    = out_data.msg_kind;

  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance && emit |=> out_valid)
    else $error("frame result not registered");

  a_too_long_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_TOO_LONG |->
      ({1'b0, out_payload_len} + FRAME_EXTRA) > MAX_FRAME_C)
    else $error("oversize status on a frame within bound");

  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_TOO_LONG |->
      ({1'b0, out_payload_len} + FRAME_EXTRA) <= MAX_FRAME_C)
    else $error("completed frame exceeds bound");

  a_no_status3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_CHECKSUM ||
      out_status == ST_TOO_LONG)
    else $error("undefined status code");

endmodule

// ===== verif/tb.sv =====
module tb;
  import ubxfr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 1520;
  localparam int DRAIN_MARK   = -1;
  localparam int TAIL_CYCLES  = 20;
  localparam int REPORT_MAX   = 10;
  localparam int QUIET_FROM   = 600;
  localparam int QUIET_TO     = 1100;

  localparam int CK_GOOD      = 0;
  localparam int CK_BAD_A     = 1;
  localparam int CK_BAD_B     = 2;
  localparam int CK_LAST_SYNC = 3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [7:0]  out_msg_class;
  logic [7:0]  out_msg_id;
  logic [15:0] out_payload_len;
  logic [1:0]  out_msg_kind;

  ubx_frame_receiver_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_msg_class   (out_msg_class),
    .out_msg_id      (out_msg_id),
    .out_payload_len (out_payload_len),
    .out_msg_kind    (out_msg_kind)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int      rx_bytes[$];
  result_t frames_due[$];

  logic [7:0]       prev_hunt;
  logic [CNT_W-1:0] frame_pos;
  logic [CNT_W-1:0] frame_len;
  logic [7:0]       sum_a;
  logic [7:0]       sum_b;
  logic [7:0]       cls_q;
  logic [7:0]       id_q;
  logic [7:0]       rx_sum_a;

  bit      byte_taken = 1'b0;
  int      cyc = 0;
  int      errors = 0;
  int      bytes_sent = 0;
  int      n_ok = 0;
  int      n_cksum = 0;
  int      n_long = 0;
  result_t got;
  result_t want;
  result_t fresh;

  function automatic logic [1:0] kind_of(input logic [7:0] c, input logic [7:0] i);
    logic [1:0] k;
    case ({c, i})
      TYPE_NAV_SOLUTION:   k = KIND_NAV_SOL;
      TYPE_TRACK_MEAS:     k = KIND_TRK_MEAS;
      TYPE_TRACK_SUBFRAME: k = KIND_TRK_SFRM;
      default:             k = KIND_OTHER;
    endcase
    return k;
  endfunction

  function automatic result_t frame_summary(input logic [1:0] st);
    result_t r;
    logic [CNT_W-1:0] plen;
    plen          = frame_len - FRAME_EXTRA;
    r.status      = st;
    r.msg_class   = cls_q;
    r.msg_id      = id_q;
    r.payload_len = plen[15:0];
    r.msg_kind    = kind_of(cls_q, id_q);
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output result_t r);
    logic [CNT_W-1:0] pos;
    bit               hit;
    r = '0;
    if (frame_pos == POS_HUNT) begin
      hit = (prev_hunt == SYNC_FIRST) && (b == SYNC_SECOND);
      prev_hunt = b;
      if (hit) begin
        frame_pos = POS_CLASS;
        sum_a = 8'd0;
        sum_b = 8'd0;
      end
      return 1'b0;
    end
    pos = frame_pos;
    frame_pos = frame_pos + CNT_W'(1);
    if (pos <= POS_LEN_HI) begin
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
      if (pos == POS_CLASS) begin
        cls_q = b;
      end else if (pos == POS_ID) begin
        id_q = b;
      end else if (pos == POS_LEN_LO) begin
        frame_len = CNT_W'(b);
      end else begin
        frame_len = CNT_W'({b, frame_len[7:0]}) + FRAME_EXTRA;
        if (frame_len > MAX_FRAME_C) begin
          frame_pos = POS_HUNT;
          r = frame_summary(ST_TOO_LONG);
          return 1'b1;
        end
      end
      return 1'b0;
    end
    if (pos < frame_len - CHECK_BYTES) begin
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
      return 1'b0;
    end
    if (pos == frame_len - CHECK_BYTES) begin
      rx_sum_a = b;
      return 1'b0;
    end
    frame_pos = POS_HUNT;
    r = frame_summary((rx_sum_a == sum_a && b == sum_b) ? ST_OK : ST_CHECKSUM);
    return 1'b1;
  endfunction

  task automatic add_frame(input logic [7:0] c, input logic [7:0] i, input int len,
                           input int ck_mode, input bit sync_fill);
    logic [7:0] a;
    logic [7:0] bb;
    logic [7:0] body[$];
    logic [7:0] v;
    body = {c, i, 8'(len), 8'(len >> 8)};
    for (int k = 0; k < len; k++) begin
      if (sync_fill) begin
        v = (k % 2 == 0) ? SYNC_FIRST : SYNC_SECOND;
      end else begin
        v = 8'($urandom);
      end
      body.push_back(v);
    end
    a = 8'd0;
    bb = 8'd0;
    foreach (body[k]) begin
      a = a + body[k];
      bb = bb + a;
    end
    if (ck_mode == CK_BAD_A) begin
      a = a ^ 8'(1 << $urandom_range(7));
    end else if (ck_mode == CK_BAD_B) begin
      bb = bb ^ 8'($urandom_range(255, 1));
    end else if (ck_mode == CK_LAST_SYNC) begin
      bb = SYNC_FIRST;
    end
    rx_bytes.push_back(SYNC_FIRST);
    rx_bytes.push_back(SYNC_SECOND);
    foreach (body[k]) rx_bytes.push_back(body[k]);
    rx_bytes.push_back(a);
    rx_bytes.push_back(bb);
  endtask

  task automatic add_header(input logic [7:0] c, input logic [7:0] i, input int len);
    rx_bytes.push_back(SYNC_FIRST);
    rx_bytes.push_back(SYNC_SECOND);
    rx_bytes.push_back(c);
    rx_bytes.push_back(i);
    rx_bytes.push_back(8'(len));
    rx_bytes.push_back(8'(len >> 8));
  endtask

  task automatic pick_type(output logic [7:0] c, output logic [7:0] i);
    logic [15:0] t;
    case ($urandom_range(4))
      0: t = TYPE_NAV_SOLUTION;
      1: t = TYPE_TRACK_MEAS;
      2: t = TYPE_TRACK_SUBFRAME;
      default: t = 16'($urandom);
    endcase
    c = t[15:8];
    i = t[7:0];
  endtask

  function automatic int pick_len();
    return ($urandom_range(9) == 0) ? $urandom_range(300, 25) : $urandom_range(24);
  endfunction

  task automatic build_random();
    int         start;
    int         len;
    int         r;
    logic [7:0] c;
    logic [7:0] i;
    start = rx_bytes.size();
    while (rx_bytes.size() - start < RANDOM_BYTES) begin
      r = $urandom_range(99);
      pick_type(c, i);
      if (r < 62) begin
        add_frame(c, i, pick_len(), CK_GOOD, $urandom_range(9) == 0);
      end else if (r < 72) begin
        add_frame(c, i, pick_len(), $urandom_range(1) ? CK_BAD_A : CK_BAD_B, 1'b0);
      end else if (r < 80) begin
        add_header(c, i, $urandom_range(65535, MAX_FRAME - 7));
      end else if (r < 88) begin
        len = $urandom_range(20);
        add_header(c, i, len);
        repeat ($urandom_range(len + 2)) rx_bytes.push_back($urandom_range(255));
      end else begin
        repeat ($urandom_range(8, 1)) begin
          rx_bytes.push_back(($urandom_range(9) < 3) ? SYNC_FIRST : $urandom_range(255));
        end
      end
      if ($urandom_range(99) < 3) rx_bytes.push_back(DRAIN_MARK);
    end
  endtask

  task automatic build_directed();
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'hFF);
    rx_bytes.push_back(SYNC_FIRST);
    add_frame(8'h01, 8'h06, 0, CK_GOOD, 1'b0);
    add_frame(8'h03, 8'h10, 1, CK_GOOD, 1'b0);
    add_frame(8'h03, 8'h0F, 5, CK_GOOD, 1'b0);
    add_frame(8'hFF, 8'hFF, 3, CK_BAD_A, 1'b0);
    add_frame(8'h00, 8'h00, 2, CK_BAD_B, 1'b0);
    add_frame(8'h01, 8'h06, 4, CK_GOOD, 1'b1);
    add_frame(8'hAA, 8'h55, 2, CK_LAST_SYNC, 1'b0);
    rx_bytes.push_back(SYNC_SECOND);
    add_frame(8'h01, 8'h07, 0, CK_GOOD, 1'b0);
    add_header(8'h02, 8'h15, MAX_FRAME - 7);
    add_frame(8'h0A, 8'h04, 0, CK_GOOD, 1'b0);
    add_header(8'h03, 8'h10, 16'hFFFF);
    add_header(8'h01, 8'h06, 16'h8000);
    add_frame(8'h03, 8'h0F, 6, CK_BAD_A, 1'b0);
    rx_bytes.push_back(SYNC_SECOND);
    rx_bytes.push_back(SYNC_FIRST);
    rx_bytes.push_back(DRAIN_MARK);
  endtask

  function automatic bit may_idle();
    return !(cyc >= QUIET_FROM && cyc < QUIET_TO) && ($urandom_range(99) < 24);
  endfunction

  always @(negedge clk) begin
    int byte_v;
    if (rst_n) begin
      if (!in_valid || byte_taken) begin
        if (rx_bytes.size() > 0 && rx_bytes[0] == DRAIN_MARK && frames_due.size() == 0) begin
          void'(rx_bytes.pop_front());
        end
        if (rx_bytes.size() > 0 && rx_bytes[0] != DRAIN_MARK && !may_idle()) begin
          byte_v = rx_bytes.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= byte_v[7:0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= may_idle();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      cyc++;
      byte_taken = in_valid && !in_stall;
      if (byte_taken) begin
        bytes_sent++;
        if (parse_byte(in_data_byte, fresh)) frames_due.push_back(fresh);
      end
      if (out_valid && !out_stall) begin
        got = '{out_status, out_msg_class, out_msg_id, out_payload_len, out_msg_kind};
        if (frames_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $display("unexpected result at cycle %0d: st=%0d cls=%h id=%h len=%0d kind=%0d",
                     cyc, got.status, got.msg_class, got.msg_id, got.payload_len,
                     got.msg_kind);
          end
        end else begin
          want = frames_due.pop_front();
          if (got.status != want.status || got.msg_class != want.msg_class ||
              got.msg_id != want.msg_id || got.payload_len != want.payload_len ||
              got.msg_kind != want.msg_kind) begin
            errors++;
            if (errors <= REPORT_MAX) begin
              $display("mismatch at cycle %0d: exp st=%0d cls=%h id=%h len=%0d kind=%0d",
                       cyc, want.status, want.msg_class, want.msg_id, want.payload_len,
                       want.msg_kind);
              $display("                      got st=%0d cls=%h id=%h len=%0d kind=%0d",
                       got.status, got.msg_class, got.msg_id, got.payload_len,
                       got.msg_kind);
            end
          end
          case (want.status)
            ST_OK:       n_ok++;
            ST_CHECKSUM: n_cksum++;
            default:     n_long++;
          endcase
        end
      end
      if (cyc > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    out_stall = 1'b0;
    prev_hunt = 8'h00;
    frame_pos = POS_HUNT;
    frame_len = '0;
    sum_a = 8'h00;
    sum_b = 8'h00;
    cls_q = 8'h00;
    id_q = 8'h00;
    rx_sum_a = 8'h00;
    build_directed();
    build_random();
    add_header(8'h7F, 8'h80, MAX_FRAME - 8);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (rx_bytes.size() != 0 || in_valid || frames_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d bytes streamed in %0d cycles with random stalls on both sides",
             bytes_sent, cyc);
    $display("frames checked: %0d good, %0d bad checksum, %0d oversized",
             n_ok, n_cksum, n_long);
    if (errors == 0 && frames_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ubxfr_pkg.sv
src/ubxfr_frame_parser.sv
src/ubxfr_result_reg.sv
src/ubx_frame_receiver_core.sv
verif/tb.sv
